// ===== src/u16u8_pkg.sv =====
`default_nettype none

package u16u8_pkg;

	// Input transaction: one UTF-16 code unit
	typedef struct packed {
		logic [15:0] code_unit;
		logic        string_end;
	} unit_t;

	// Output transaction: one UTF-8 byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_done;
	} utf8_t;

	localparam int JOB_BYTES = 6;
	localparam int ENC_BYTES = 4;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;

	localparam logic [20:0] SUPP_BASE  = 21'h010000;
	localparam logic [20:0] REPL_CP    = 21'h00FFFD;
	localparam logic [20:0] LIM_1BYTE  = 21'h000080;
	localparam logic [20:0] LIM_2BYTE  = 21'h000800;
	localparam logic [20:0] LIM_3BYTE  = 21'h010000;

	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT   = 8'h80;
	localparam logic [5:0] CONT_MASK = 6'h3F;

	typedef logic [2:0] blen_t;

	typedef struct packed {
		logic [ENC_BYTES-1:0][7:0] b;
		blen_t                     len;
	} enc_t;

	// One queued job: all bytes caused by one code unit, first byte in slot 0
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		blen_t                     len;
		logic                      str_end;
	} job_t;

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t e;
		e = '0;
		if (cp < LIM_1BYTE) begin
			e.b[0] = cp[7:0];
			e.len  = 3'd1;
		end else if (cp < LIM_2BYTE) begin
			e.b[0] = LEAD_2 | {3'b000, cp[10:6]};
			e.b[1] = CONT | {2'b00, cp[5:0] & CONT_MASK};
			e.len  = 3'd2;
		end else if (cp < LIM_3BYTE) begin
			e.b[0] = LEAD_3 | {4'b0000, cp[15:12]};
			e.b[1] = CONT | {2'b00, cp[11:6]};
			e.b[2] = CONT | {2'b00, cp[5:0]};
			e.len  = 3'd3;
		end else begin
			e.b[0] = LEAD_4 | {5'b00000, cp[20:18]};
			e.b[1] = CONT | {2'b00, cp[17:12]};
			e.b[2] = CONT | {2'b00, cp[11:6]};
			e.b[3] = CONT | {2'b00, cp[5:0]};
			e.len  = 3'd4;
		end
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== src/utf16_to_utf8_stream.sv =====
`default_nettype none

// UTF-16 to UTF-8 stream converter. Each unit_data transaction carries one
// UTF-16 code unit and a flag marking the last unit of a string; each utf8_data
// transaction carries one UTF-8 byte, with run_last on the final byte caused by
// a unit and string_done on that byte when the unit ended the string. A high
// surrogate is held and produces nothing until the next unit: a low surrogate
// joins it into four bytes, anything else first yields U+FFFD (EF BF BD) and is
// then converted on its own. Lone low surrogates and a high surrogate that ends
// the string also become U+FFFD. The front stage classifies and encodes a unit
// in the cycle it is accepted and takes a new unit every cycle while its
// two-entry job queue has room; the back stage sends one byte per cycle while
// the receiver is ready, from the queue head through a registered output. A
// unit therefore causes 0 to 6 bytes, and that single-byte output port sets
// the sustained rate. The first byte of a unit passes through the job queue
// and then the output register before it is presented on utf8_data.
module utf16_to_utf8_stream (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              unit_valid,
	output logic                   unit_ready,
	input  wire u16u8_pkg::unit_t  unit_data,
	output logic                   utf8_valid,
	input  wire logic              utf8_ready,
	output u16u8_pkg::utf8_t       utf8_data
);

	// front to queue
	logic             push;
	u16u8_pkg::job_t  push_job;
	logic             q_full;

	// queue to back
	logic             head_valid;
	u16u8_pkg::job_t  head_job;
	logic             pop;

	// Classify the unit, track the held surrogate, build the byte job
	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.unit_valid (unit_valid),
		.unit_ready (unit_ready),
		.unit_data  (unit_data),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	// Hold jobs so the input side keeps moving while bytes drain
	u16u8_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	// Serialize each job one byte per transaction
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.utf8_valid (utf8_valid),
		.utf8_ready (utf8_ready),
		.utf8_data  (utf8_data)
	);

endmodule

`default_nettype wire

// ===== src/u16u8_front.sv =====
`default_nettype none

module u16u8_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              unit_valid,
	output logic                   unit_ready,
	input  wire u16u8_pkg::unit_t  unit_data,
	input  wire logic              q_full,
	output logic                   push,
	output u16u8_pkg::job_t        push_job
);

	logic        pend_q, pend_d;
	logic [9:0]  hi_q, hi_d;
	logic        is_high, is_low, pre;
	logic [15:0] u;
	logic [20:0] pair_cp;
	u16u8_pkg::enc_t main_enc, repl_enc;

	assign u          = unit_data.code_unit;
	assign is_high    = (u >= u16u8_pkg::HIGH_FIRST) && (u <= u16u8_pkg::HIGH_LAST);
	assign is_low     = (u >= u16u8_pkg::LOW_FIRST) && (u <= u16u8_pkg::LOW_LAST);
	assign pair_cp    = u16u8_pkg::SUPP_BASE + {1'b0, hi_q, u[9:0]};
	assign repl_enc   = u16u8_pkg::encode(u16u8_pkg::REPL_CP);
	assign unit_ready = !q_full;

	always_comb begin
		pend_d   = pend_q;
		hi_d     = hi_q;
		pre      = 1'b0;
		main_enc = '0;
		if (pend_q && is_low) begin
			main_enc = u16u8_pkg::encode(pair_cp);
			pend_d   = 1'b0;
			hi_d     = '0;
		end else begin
			// held high surrogate without a partner: replace, then treat unit afresh
			pre    = pend_q;
			pend_d = 1'b0;
			hi_d   = '0;
			if (is_high && !unit_data.string_end) begin
				pend_d = 1'b1;
				hi_d   = u[9:0];
			end else if (is_high || is_low) begin
				main_enc = repl_enc;
			end else begin
				main_enc = u16u8_pkg::encode({5'b00000, u});
			end
		end
	end

	always_comb begin
		push_job         = '0;
		push_job.str_end = unit_data.string_end;
		if (pre) begin
			push_job.bytes[0] = repl_enc.b[0];
			push_job.bytes[1] = repl_enc.b[1];
			push_job.bytes[2] = repl_enc.b[2];
			push_job.bytes[3] = main_enc.b[0];
			push_job.bytes[4] = main_enc.b[1];
			push_job.bytes[5] = main_enc.b[2];
			push_job.len      = 3'd3 + main_enc.len;
		end else begin
			push_job.bytes[3:0] = main_enc.b;
			push_job.len        = main_enc.len;
		end
	end

	// drop units that leave nothing to send (a held high surrogate)
	assign push = unit_valid && unit_ready && (push_job.len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			hi_q   <= '0;
		end else if (unit_valid && unit_ready) begin
			pend_q <= pend_d;
			hi_q   <= hi_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/u16u8_fifo.sv =====
`default_nettype none

module u16u8_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire u16u8_pkg::job_t  push_job,
	output logic                  full,
	output logic                  head_valid,
	output u16u8_pkg::job_t       head_job,
	input  wire logic             pop
);

	// Two entries at fixed places: the head and the one waiting behind it
	u16u8_pkg::job_t  head_q, next_q;
	logic [1:0]       cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_job   = head_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				// advance the waiting entry to the head
				head_q <= next_q;
				if (push) begin
					next_q <= push_job;
				end
			end else if (push) begin
				head_q <= push_job;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= push_job;
			end else begin
				next_q <= push_job;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/u16u8_back.sv =====
`default_nettype none

module u16u8_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire u16u8_pkg::job_t  head_job,
	output logic                  pop,
	output logic                  utf8_valid,
	input  wire logic             utf8_ready,
	output u16u8_pkg::utf8_t      utf8_data
);

	logic              out_valid_q;
	u16u8_pkg::utf8_t  out_q;
	u16u8_pkg::blen_t  idx_q;
	logic [7:0]        sel_byte;
	logic              is_last, load;

	always_comb begin
		case (idx_q)
			3'd0:    sel_byte = head_job.bytes[0];
			3'd1:    sel_byte = head_job.bytes[1];
			3'd2:    sel_byte = head_job.bytes[2];
			3'd3:    sel_byte = head_job.bytes[3];
			3'd4:    sel_byte = head_job.bytes[4];
			3'd5:    sel_byte = head_job.bytes[5];
			default: sel_byte = 8'h00;
		endcase
	end

	assign is_last    = (idx_q == head_job.len - 3'd1);
	assign load       = head_valid && (!out_valid_q || utf8_ready);
	assign pop        = load && is_last;
	assign utf8_valid = out_valid_q;
	assign utf8_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= is_last ? '0 : idx_q + 3'd1;
		end else if (utf8_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= sel_byte;
			out_q.run_last    <= is_last;
			out_q.string_done <= is_last && head_job.str_end;
		end
	end

	a_pop_shows_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid_q && out_q.run_last))
		else $error("retired job without a last byte on the output");

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.string_done) |-> out_q.run_last)
		else $error("string end flagged on a byte that does not end its run");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head_job.len))
		else $error("byte index past the end of the queued job");

	a_job_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head_job.len != '0))
		else $error("empty job reached the serializer");

endmodule

`default_nettype wire
